[rtl/nest_pkg.sv]
package nest_pkg;

   localparam int TableDepth = 64;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam logic [15:0] RadiusReset = 16'd10000;

   typedef enum logic [1:0] {
      FUNC_INSERT        = 2'd0,
      FUNC_REMOVE        = 2'd1,
      FUNC_NEAREST       = 2'd2,
      FUNC_NEAREST_STATE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DUP    = 2'd1,
      ST_FULL   = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [15:0]        object_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [3:0]         obj_state;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [15:0] nearest_id;
      logic [1:0] status;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic [15:0]        id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [3:0]         st;
   } entry_type;

   // controls broadcast from the sequencer to every cell
   typedef struct packed {
      logic rotate;   // every cell takes its right neighbor's entry
      logic load;     // last cell takes the new entry
   } cell_ctl_type;

endpackage

[rtl/nest_cell.sv]
// One table slot; in a rotation it takes its neighbor's entry.
module nest_cell (
   input  logic                  clock,
   input  nest_pkg::cell_ctl_type ctl,
   input  nest_pkg::entry_type   nbr_in,
   input  nest_pkg::entry_type   new_in,
   input  logic                  is_last,
   output nest_pkg::entry_type   entry_out
);
   import nest_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // pick neighbor or new entry
   always_comb begin
      entry_in = entry_ff;
      if (ctl.rotate) begin
         entry_in = (is_last && ctl.load) ? new_in : nbr_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
endmodule

[rtl/nest_dist.sv]
// Pipelined squared distance of the head entry to the query point.
module nest_dist (
   input  logic                clock,
   input  nest_pkg::req_type   req,
   input  nest_pkg::entry_type head,
   output logic [33:0]         dist2
);
   import nest_pkg::*;

   logic [16:0] ax_in, ay_in, az_in;
   logic [33:0] sx_ff, sy_ff, sz_ff;
   logic [33:0] dist2_ff;
   logic signed [16:0] dx, dy, dz;

   // absolute differences
   always_comb begin
      dx = 17'(signed'(req.pos_x)) - 17'(signed'(head.x));
      dy = 17'(signed'(req.pos_y)) - 17'(signed'(head.y));
      dz = 17'(signed'(req.pos_z)) - 17'(signed'(head.z));
      ax_in = dx[16] ? 17'(-dx) : 17'(dx);
      ay_in = dy[16] ? 17'(-dy) : 17'(dy);
      az_in = dz[16] ? 17'(-dz) : 17'(dz);
   end

   // square, then sum
   always_ff @(posedge clock) begin
      sx_ff    <= 34'(ax_in) * 34'(ax_in);
      sy_ff    <= 34'(ay_in) * 34'(ay_in);
      sz_ff    <= 34'(az_in) * 34'(az_in);
      dist2_ff <= sx_ff + sy_ff + sz_ff;
   end

   assign dist2 = dist2_ff;
endmodule

[rtl/nearest_entry_search_table_core.sv]
// Nearest-entry search table.
// Input: raise start with req for one cycle while busy is low; the item is
// taken at that edge. Insert, remove, nearest and state-filtered nearest.
// Output: one result per item, shown on rsp for one cycle with rsp_valid.
// The receiver cannot stall; results are never held.
// Entries sit in a ring of cells. Every item rotates the whole ring once,
// one cell per cycle, so the head cell sees each slot in table order.
// Remove drops the matching entry during the rotation; insert appends at
// the end. Distances run through a two-stage squaring pipe at the head.
// Sequence: the start edge enters the scan state, which covers the rotation
// and the pipe drain, then the done state finishes; rsp_valid is registered
// from the done state and the result transfers at the next edge. Busy stays
// high through scan and done, so a new item is taken at the earliest at the
// edge that takes the result. csr_wr_en writes search_radius (reset 10000);
// the user writes it only while idle, the block does not enforce this.
// Reset empties the table (count 0) and returns to idle; no clearing pass.
module nearest_entry_search_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nest_pkg::req_type req_data,
   output logic              rsp_valid,
   output nest_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import nest_pkg::*;

   localparam int StepW = $clog2(TableDepth + 4);

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [15:0] radius_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [StepW-1:0] step_ff, step_in;   // cycles into the scan
   logic         hit_ff, hit_in;         // remove or duplicate matched
   logic         dropped_ff, dropped_in;
   logic [33:0]  best_ff, best_in;
   logic         found_ff, found_in;
   logic [15:0]  nid_ff, nid_in;
   logic         rvalid_ff;
   rsp_type      rsp_ff, rsp_in;
   logic [CntW-1:0] rd_ff;               // index of head entry entering pipe
   logic         vp1_ff, vp2_ff;         // pipe valid
   logic [15:0]  idp1_ff, idp2_ff;
   logic         rot, drop, is_q;
   cell_ctl_type ctl;
   entry_type    cells [TableDepth];
   entry_type    head, new_e, tail_src;
   logic [33:0]  dist2;

   assign head = cells[0];
   assign is_q = req_ff.func[1];
   assign new_e = '{id: req_ff.object_id, x: req_ff.pos_x, y: req_ff.pos_y,
                    z: req_ff.pos_z, st: req_ff.obj_state};

   // ring rotates while the scan step is below TableDepth
   assign rot  = (state_ff == S_SCAN) && (step_ff < StepW'(TableDepth));
   assign drop = rot && (req_ff.func == FUNC_REMOVE) && !dropped_ff
                 && (rd_ff < count_ff) && (head.id == req_ff.object_id);

   // once an entry is dropped the tail skips it and takes the next one
   assign tail_src = (drop || dropped_ff) ? cells[1] : cells[0];
   assign ctl = '{rotate: rot,
                  load: rot && (req_ff.func == FUNC_INSERT) && (rd_ff == count_ff)};

   // ring of cells; the tail takes the head, the new entry or the head's neighbor
   genvar g;
   generate
      for (g = 0; g < TableDepth; g++) begin : g_cell
         nest_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .nbr_in   ((g == TableDepth - 1) ? tail_src : cells[(g + 1) % TableDepth]),
            .new_in   (new_e),
            .is_last  (g == TableDepth - 1),
            .entry_out(cells[g])
         );
      end
   endgenerate

   nest_dist u_dist (
      .clock(clock),
      .req  (req_ff),
      .head (head),
      .dist2(dist2)
   );

   // scan sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      hit_in     = hit_ff;
      dropped_in = dropped_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      nid_in     = nid_ff;
      rsp_in     = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in   = S_SCAN;
               step_in    = '0;
               hit_in     = 1'b0;
               dropped_in = 1'b0;
               best_in    = 34'(radius_ff) * 34'(radius_ff);
               found_in   = 1'b0;
               nid_in     = '0;
            end
         end
         S_SCAN: begin
            step_in = step_ff + 1'b1;
            if (rot && rd_ff < count_ff && head.id == req_ff.object_id) begin
               hit_in = 1'b1;
            end
            if (drop) begin
               dropped_in = 1'b1;
            end
            if (vp2_ff && dist2 < best_ff) begin
               best_in  = dist2;
               found_in = 1'b1;
               nid_in   = idp2_ff;
            end
            if (step_ff == StepW'(TableDepth + 3)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
            rsp_in   = '{found: 1'b0, nearest_id: '0, status: ST_OK};
            case (func_type'(req_ff.func))
               FUNC_INSERT: begin
                  if (hit_ff) begin
                     rsp_in.status = ST_DUP;
                  end else if (count_ff >= CntW'(TableDepth)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (hit_ff) begin
                     count_in = count_ff - 1'b1;
                  end else begin
                     rsp_in.status = ST_ABSENT;
                  end
               end
               default: begin
                  rsp_in.found      = found_ff;
                  rsp_in.nearest_id = nid_ff;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         radius_ff <= RadiusReset;
         rvalid_ff <= 1'b0;
         vp1_ff    <= 1'b0;
         vp2_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= (state_ff == S_DONE);
         vp1_ff    <= rot && is_q && (rd_ff < count_ff)
                      && (req_ff.func == FUNC_NEAREST || head.st == req_ff.obj_state);
         vp2_ff    <= vp1_ff;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
         rd_ff  <= '0;
      end else if (rot) begin
         rd_ff  <= rd_ff + 1'b1;
      end
      step_ff    <= step_in;
      hit_ff     <= hit_in;
      dropped_ff <= dropped_in;
      best_ff    <= best_in;
      found_ff   <= found_in;
      nid_ff     <= nid_in;
      rsp_ff     <= rsp_in;
      idp1_ff    <= head.id;
      idp2_ff    <= idp1_ff;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid) else $error("result missing");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TableDepth)) else $error("count overflow");
endmodule

[test/tb_nearest_entry_search_table_core.sv]
module tb_nearest_entry_search_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import nest_pkg::*;

   localparam int Depth = TableDepth;
   localparam int LatencyCycles = TableDepth + 8;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [15:0]       csr_wr_data;

   // table shadow and current radius
   logic [15:0]        tbl_id[Depth];
   logic signed [15:0] tbl_x[Depth];
   logic signed [15:0] tbl_y[Depth];
   logic signed [15:0] tbl_z[Depth];
   logic [3:0]         tbl_st[Depth];
   int                 tbl_count;
   logic [15:0]        radius;

   rsp_type pending_rsp[$];
   int      mismatch_count;
   int      rsp_count;
   int      item_count;
   bit      allow_gaps;

   nearest_entry_search_table_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int find_entry(logic [15:0] id);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_id[i] == id) return i;
      end
      return tbl_count;
   endfunction

   function automatic longint unsigned sq_dist(logic signed [15:0] a,
                                               logic signed [15:0] b);
      longint signed d;
      d = longint'(a) - longint'(b);
      return longint'(d * d);
   endfunction

   // apply one transfer to the shadow table and return the expected result
   function automatic rsp_type table_step(req_type r);
      rsp_type         o;
      int              k;
      longint unsigned best;
      longint unsigned d2;
      o = '0;
      o.status = ST_OK;
      case (func_type'(r.func))
         FUNC_INSERT: begin
            if (find_entry(r.object_id) < tbl_count) o.status = ST_DUP;
            else if (tbl_count >= Depth) o.status = ST_FULL;
            else begin
               tbl_id[tbl_count] = r.object_id;
               tbl_x[tbl_count]  = r.pos_x;
               tbl_y[tbl_count]  = r.pos_y;
               tbl_z[tbl_count]  = r.pos_z;
               tbl_st[tbl_count] = r.obj_state;
               tbl_count++;
            end
         end
         FUNC_REMOVE: begin
            k = find_entry(r.object_id);
            if (k >= tbl_count) o.status = ST_ABSENT;
            else begin
               for (int i = k; i + 1 < tbl_count; i++) begin
                  tbl_id[i] = tbl_id[i+1];
                  tbl_x[i]  = tbl_x[i+1];
                  tbl_y[i]  = tbl_y[i+1];
                  tbl_z[i]  = tbl_z[i+1];
                  tbl_st[i] = tbl_st[i+1];
               end
               tbl_count--;
            end
         end
         default: begin
            best = longint'(radius) * longint'(radius);
            for (int i = 0; i < tbl_count; i++) begin
               if (r.func == FUNC_NEAREST_STATE && tbl_st[i] != r.obj_state) continue;
               d2 = sq_dist(r.pos_x, tbl_x[i]) + sq_dist(r.pos_y, tbl_y[i])
                  + sq_dist(r.pos_z, tbl_z[i]);
               if (d2 < best) begin
                  best = d2;
                  o.found = 1'b1;
                  o.nearest_id = tbl_id[i];
               end
            end
         end
      endcase
      return o;
   endfunction

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found || rsp_data.nearest_id !== want.nearest_id
                || rsp_data.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected found=%0d id=%0d status=%0d, %s",
                           want.found, want.nearest_id, want.status,
                           $sformatf("got found=%0d id=%0d status=%0d",
                                     rsp_data.found, rsp_data.nearest_id,
                                     rsp_data.status));
            end
         end
      end
   end

   // send one transfer, with an optional idle burst before it
   task automatic send_item(func_type f, logic [15:0] id, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z, logic [3:0] st);
      req_type r;
      r.func = f;
      r.object_id = id;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.obj_state = st;
      if (allow_gaps && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) @(posedge clock);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.insert(pending_rsp.size(), table_step(r));
      item_count++;
      start <= 1'b0;
      req_data <= '0;
      // the block is idle now; let the drop settle before the next item
      @(posedge clock);
   endtask

   // hold until every expected result has arrived and the block settles
   task automatic drain();
      int guard;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LatencyCycles) @(posedge clock);
   endtask

   task automatic write_radius(logic [15:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radius = value;
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom());
         1: return 16'(32'sh7fff - int'($urandom_range(0, 3)));
         2: return 16'(-32'sh8000 + int'($urandom_range(0, 3)));
         default: return 16'(int'($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   function automatic logic [15:0] rand_id();
      return ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 90));
   endfunction

   task automatic test_directed();
      send_item(FUNC_NEAREST, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_REMOVE, 16'd5, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_INSERT, 16'hffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 4'hf);
      send_item(FUNC_INSERT, 16'h0000, 16'sh8000, 16'sh8000, 16'sh8000, 4'h0);
      send_item(FUNC_INSERT, 16'hffff, 16'sd1, 16'sd1, 16'sd1, 4'h1);
      send_item(FUNC_INSERT, 16'd10, 16'sd3, 16'sd0, 16'sd0, 4'h5);
      send_item(FUNC_INSERT, 16'd11, -16'sd3, 16'sd0, 16'sd0, 4'h5);
      // tie: the earlier entry wins
      send_item(FUNC_NEAREST, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_NEAREST_STATE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'h5);
      send_item(FUNC_NEAREST_STATE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'ha);
      send_item(FUNC_NEAREST, 16'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 4'd0);
      send_item(FUNC_NEAREST, 16'd0, 16'sh8000, 16'sh7fff, 16'sh8000, 4'd0);
      send_item(FUNC_REMOVE, 16'd10, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_NEAREST, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_REMOVE, 16'd10, 16'sd0, 16'sd0, 16'sd0, 4'd0);
   endtask

   task automatic test_radius_extremes();
      write_radius(16'd0);
      send_item(FUNC_NEAREST, 16'd0, -16'sd3, 16'sd0, 16'sd0, 4'd0);
      write_radius(16'd3);
      send_item(FUNC_NEAREST, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_NEAREST, 16'd0, -16'sd1, 16'sd0, 16'sd0, 4'd0);
      write_radius(16'hffff);
      send_item(FUNC_NEAREST, 16'd0, 16'sh7fff, 16'sh8000, 16'sd0, 4'd0);
      send_item(FUNC_NEAREST_STATE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 4'hf);
   endtask

   // fill past capacity, check full and duplicate precedence, then empty
   task automatic test_full_table();
      for (int i = 0; i < Depth + 2; i++)
         send_item(FUNC_INSERT, 16'(1000 + i), rand_coord(), rand_coord(), rand_coord(),
                   4'($urandom()));
      send_item(FUNC_INSERT, 16'd1000, 16'sd0, 16'sd0, 16'sd0, 4'd0);
      send_item(FUNC_NEAREST, 16'd0, rand_coord(), rand_coord(), rand_coord(), 4'd0);
      while (tbl_count > 0) begin
         send_item(FUNC_REMOVE, tbl_id[$urandom_range(0, tbl_count - 1)],
                   16'sd0, 16'sd0, 16'sd0, 4'd0);
      end
   endtask

   task automatic test_random(int n);
      func_type   f;
      logic [3:0] st;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: f = FUNC_INSERT;
            3, 4:    f = FUNC_REMOVE;
            5, 6:    f = FUNC_NEAREST;
            default: f = FUNC_NEAREST_STATE;
         endcase
         st = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
         if (f == FUNC_REMOVE && tbl_count > 0 && $urandom_range(0, 3) != 0)
            send_item(f, tbl_id[$urandom_range(0, tbl_count - 1)], rand_coord(),
                      rand_coord(), rand_coord(), st);
         else
            send_item(f, rand_id(), rand_coord(), rand_coord(), rand_coord(), st);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      radius = RadiusReset;
      tbl_count = 0;
      mismatch_count = 0;
      rsp_count = 0;
      item_count = 0;
      allow_gaps = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_radius_extremes();
      write_radius(16'd300);
      test_random(200);
      test_full_table();
      write_radius(16'd40000);
      test_random(120);
      write_radius(16'($urandom()));
      test_random(100);
      // last stretch without gaps
      allow_gaps = 1'b0;
      write_radius(16'd150);
      test_random(80);
      drain();

      $display("covered %0d items and %0d results over several radius settings,",
               item_count, rsp_count);
      $display("including full table, duplicates, absent removes and filtered queries");
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("tb_nearest_entry_search_table_core OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_rsp.size());
         $display("tb_nearest_entry_search_table_core NOT OK");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #5ms;
      $display("timeout");
      $display("tb_nearest_entry_search_table_core NOT OK");
      $finish;
   end
endmodule
